// ----- rtl/pau_pkg.sv -----
// Package: shared types, constants and helpers for the particle attractor update unit.
`timescale 1ns / 1ps
package pau_pkg;

    localparam int FIELD_WIDTH_DEF  = 1920;
    localparam int FIELD_HEIGHT_DEF = 1080;

    localparam int POS_W  = 27;
    localparam int VEL_W  = 32;
    localparam int PIX_W  = 11;
    localparam int DT_W   = 16;
    localparam int STR_W  = 32;
    localparam int CFG_W  = 32;
    localparam int IDX_W  = 3;

    // divider geometry
    localparam int NUM_W  = 91;    // |d| * strength * dt * 2^16
    localparam int DEN_W  = 55;    // dx^2 + dy^2
    localparam int QUO_W  = 34;    // quotient bits resolved; above that saturates
    localparam int DIV_LAT = QUO_W + 1;

    localparam logic [DEN_W-1:0] NEAR_D2   = DEN_W'(64'd22500 << 32);
    localparam int               GRAV_RATE = 491;
    localparam int               TENTH_Q16 = 6554;

    typedef enum logic [IDX_W-1:0] {
        CFG_ATTR_X    = 3'd0,
        CFG_ATTR_Y    = 3'd1,
        CFG_TIME_STEP = 3'd2,
        CFG_STRENGTH  = 3'd3,
        CFG_ATTR_EN   = 3'd4,
        CFG_GRAV_EN   = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic        [POS_W-1:0] pos_x;
        logic        [POS_W-1:0] pos_y;
        logic signed [VEL_W-1:0] vel_x;
        logic signed [VEL_W-1:0] vel_y;
    } t_in_item;

    typedef struct packed {
        logic        [POS_W-1:0] new_pos_x;
        logic        [POS_W-1:0] new_pos_y;
        logic signed [VEL_W-1:0] new_vel_x;
        logic signed [VEL_W-1:0] new_vel_y;
        logic        [PIX_W-1:0] pixel_x;
        logic        [PIX_W-1:0] pixel_y;
    } t_out_item;

    function automatic logic signed [VEL_W-1:0] sat32(input logic signed [37:0] v);
        logic signed [VEL_W-1:0] res;
        if (v > 38'sd2147483647) begin
            res = 32'sh7FFF_FFFF;
        end else if (v < -38'sd2147483648) begin
            res = 32'sh8000_0000;
        end else begin
            res = v[VEL_W-1:0];
        end
        return res;
    endfunction

endpackage

// ----- rtl/pau_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, saturating above 2^34.
`timescale 1ns / 1ps
module pau_div (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [pau_pkg::NUM_W-1:0]   i_num,
    input  logic [pau_pkg::DEN_W-1:0]   i_den,
    output logic [pau_pkg::QUO_W:0]     o_quo
);
    import pau_pkg::*;

    logic [DEN_W-1:0] r_rem [0:QUO_W];
    logic [QUO_W-1:0] r_low [0:QUO_W];
    logic [DEN_W-1:0] r_den [0:QUO_W];
    logic [QUO_W-1:0] r_quo [0:QUO_W];
    logic             r_sat [0:QUO_W];

    // quotient >= 2^34 exactly when the upper dividend reaches the divisor
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sat[0] <= (i_num[NUM_W-1:QUO_W] >= (NUM_W-QUO_W)'(i_den));
            r_rem[0] <= i_num[QUO_W+DEN_W-1:QUO_W];
            r_low[0] <= i_num[QUO_W-1:0];
            r_den[0] <= i_den;
            r_quo[0] <= '0;
        end
    end

    for (genvar k = 1; k <= QUO_W; k++) begin : g_stage
        logic [DEN_W:0]   n_try;
        logic             n_ge;
        logic [DEN_W:0]   n_diff;

        always_comb begin
            n_try  = {r_rem[k-1], r_low[k-1][QUO_W-k]};
            n_ge   = (n_try >= {1'b0, r_den[k-1]});
            n_diff = n_try - {1'b0, r_den[k-1]};
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= n_ge ? n_diff[DEN_W-1:0] : n_try[DEN_W-1:0];
                r_low[k] <= r_low[k-1];
                r_den[k] <= r_den[k-1];
                r_quo[k] <= {r_quo[k-1][QUO_W-2:0], n_ge};
                r_sat[k] <= r_sat[k-1];
            end
        end
    end

    assign o_quo = r_sat[QUO_W] ? {1'b1, {QUO_W{1'b0}}} : {1'b0, r_quo[QUO_W]};

endmodule

// ----- rtl/particle_attractor_update_unit.sv -----
// Top level: particle attractor update pipeline with configuration registers.
// Depth: 44 register stages, most of them in the 35-stage divider.
// Throughput: one transaction per cycle; the pipeline advances whenever the
// output register is empty or being taken.
// Reset: synchronous active low; clears all valid bits and loads register defaults.
`timescale 1ns / 1ps
module particle_attractor_update_unit #(
    parameter int FIELD_WIDTH  = pau_pkg::FIELD_WIDTH_DEF,
    parameter int FIELD_HEIGHT = pau_pkg::FIELD_HEIGHT_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  pau_pkg::t_in_item           i_data,
    output logic                        o_valid,
    input  logic                        i_stall,
    output pau_pkg::t_out_item          o_data,
    input  logic                        i_cfg_we,
    input  logic [pau_pkg::IDX_W-1:0]   i_cfg_idx,
    input  logic [pau_pkg::CFG_W-1:0]   i_cfg_data
);
    import pau_pkg::*;

    localparam int NSTG = 9 + DIV_LAT;
    localparam logic signed [33:0] X_MAX = 34'(FIELD_WIDTH * 65536);
    localparam logic signed [33:0] Y_MAX = 34'(FIELD_HEIGHT * 65536);

    typedef struct packed {
        logic        [POS_W-1:0] px;
        logic        [POS_W-1:0] py;
        logic signed [VEL_W-1:0] vx;
        logic signed [VEL_W-1:0] vy;
        logic signed [VEL_W-1:0] vxd;
        logic signed [VEL_W-1:0] vyd;
        logic                    sx;
        logic                    sy;
        logic                    near;
    } t_side;

    // configuration
    logic [PIX_W-1:0] r_attr_x, r_attr_y;
    logic [DT_W-1:0]  r_dt;
    logic [STR_W-1:0] r_strength;
    logic             r_attr_en, r_grav_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attr_x   <= '0;
            r_attr_y   <= '0;
            r_dt       <= DT_W'(1092);
            r_strength <= STR_W'(421150);
            r_attr_en  <= 1'b0;
            r_grav_en  <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_ATTR_X:    r_attr_x   <= i_cfg_data[PIX_W-1:0];
                CFG_ATTR_Y:    r_attr_y   <= i_cfg_data[PIX_W-1:0];
                CFG_TIME_STEP: r_dt       <= i_cfg_data[DT_W-1:0];
                CFG_STRENGTH:  r_strength <= i_cfg_data[STR_W-1:0];
                CFG_ATTR_EN:   r_attr_en  <= i_cfg_data[0];
                CFG_GRAV_EN:   r_grav_en  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // flow control
    logic            n_en;
    logic [NSTG-1:0] r_vld;

    assign n_en    = !(r_vld[NSTG-1] && i_stall);
    assign o_stall = !n_en;
    assign o_valid = r_vld[NSTG-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (n_en) begin
            r_vld <= {r_vld[NSTG-2:0], i_valid};
        end
    end

    // S0: input register
    t_in_item r_s0;
    always_ff @(posedge i_clk) begin
        if (n_en) begin
            r_s0 <= i_data;
        end
    end

    // S1: offsets and strength * dt
    logic signed [27:0] r1_dx, r1_dy;
    logic        [47:0] r1_t;
    t_in_item           r_s1;
    always_ff @(posedge i_clk) begin
        if (n_en) begin
            r1_dx <= $signed({1'b0, r_attr_x, 16'b0}) - $signed({1'b0, r_s0.pos_x});
            r1_dy <= $signed({1'b0, r_attr_y, 16'b0}) - $signed({1'b0, r_s0.pos_y});
            r1_t  <= 48'(r_strength) * 48'(r_dt);
            r_s1  <= r_s0;
        end
    end

    // S2: squares, pull partial products, damping products
    logic        [26:0] n_magx, n_magy;
    logic        [53:0] r2_sqx, r2_sqy;
    logic        [50:0] r2_pxl, r2_pxh, r2_pyl, r2_pyh;
    logic signed [48:0] r2_dpx, r2_dpy;
    logic               r2_sx, r2_sy;
    t_in_item           r_s2;

    always_comb begin
        n_magx = r1_dx[27] ? 27'(-r1_dx) : 27'(r1_dx);
        n_magy = r1_dy[27] ? 27'(-r1_dy) : 27'(r1_dy);
    end

    always_ff @(posedge i_clk) begin
        if (n_en) begin
            r2_sqx <= 54'(n_magx) * 54'(n_magx);
            r2_sqy <= 54'(n_magy) * 54'(n_magy);
            r2_pxl <= 51'(n_magx) * 51'(r1_t[23:0]);
            r2_pxh <= 51'(n_magx) * 51'(r1_t[47:24]);
            r2_pyl <= 51'(n_magy) * 51'(r1_t[23:0]);
            r2_pyh <= 51'(n_magy) * 51'(r1_t[47:24]);
            r2_dpx <= 49'(r_s1.vel_x) * $signed({33'b0, r_dt});
            r2_dpy <= 49'(r_s1.vel_y) * $signed({33'b0, r_dt});
            r2_sx  <= r1_dx[27];
            r2_sy  <= r1_dy[27];
            r_s2   <= r_s1;
        end
    end

    // S3: squared distance, dividends, damped velocities
    logic        [74:0] n_prx, n_pry;
    logic signed [48:0] n_tdx, n_tdy;
    logic        [DEN_W-1:0] n_d2;
    logic        [DEN_W-1:0] r3_d2;
    logic        [NUM_W-1:0] r3_numx, r3_numy;
    t_side              r3_side;

    always_comb begin
        n_prx = {r2_pxh, 24'b0} + 75'(r2_pxl);
        n_pry = {r2_pyh, 24'b0} + 75'(r2_pyl);
        n_d2  = 55'(r2_sqx) + 55'(r2_sqy);
        n_tdx = (r2_dpx + (r2_dpx[48] ? 49'sd131071 : 49'sd0)) >>> 17;
        n_tdy = (r2_dpy + (r2_dpy[48] ? 49'sd131071 : 49'sd0)) >>> 17;
    end

    always_ff @(posedge i_clk) begin
        if (n_en) begin
            r3_d2        <= n_d2;
            r3_numx      <= {n_prx, 16'b0};
            r3_numy      <= {n_pry, 16'b0};
            r3_side.px   <= r_s2.pos_x;
            r3_side.py   <= r_s2.pos_y;
            r3_side.vx   <= r_s2.vel_x;
            r3_side.vy   <= r_s2.vel_y;
            r3_side.vxd  <= sat32(38'(r_s2.vel_x) - 38'(n_tdx));
            r3_side.vyd  <= sat32(38'(r_s2.vel_y) - 38'(n_tdy));
            r3_side.sx   <= r2_sx;
            r3_side.sy   <= r2_sy;
            r3_side.near <= (n_d2 <= NEAR_D2);
        end
    end

    // divider lanes and matching side delay
    logic [QUO_W:0] n_qx, n_qy;
    t_side          r_side [0:DIV_LAT-1];

    pau_div u_div_x (
        .i_clk (i_clk),
        .i_en  (n_en),
        .i_num (r3_numx),
        .i_den (r3_d2),
        .o_quo (n_qx)
    );

    pau_div u_div_y (
        .i_clk (i_clk),
        .i_en  (n_en),
        .i_num (r3_numy),
        .i_den (r3_d2),
        .o_quo (n_qy)
    );

    always_ff @(posedge i_clk) begin
        if (n_en) begin
            r_side[0] <= r3_side;
            for (int i = 1; i < DIV_LAT; i++) begin
                r_side[i] <= r_side[i-1];
            end
        end
    end

    // S4: attraction or damping; velocities pass through unchanged when attraction is off
    t_side                   n_sd;
    logic signed [37:0]      n_sumx, n_sumy;
    logic signed [VEL_W-1:0] r4_vx, r4_vy;
    logic        [POS_W-1:0] r4_px, r4_py;

    always_comb begin
        n_sd   = r_side[DIV_LAT-1];
        n_sumx = $signed(38'(n_sd.vx)) +
                 $signed(n_sd.sx ? -38'(n_qx) : 38'(n_qx));
        n_sumy = $signed(38'(n_sd.vy)) +
                 $signed(n_sd.sy ? -38'(n_qy) : 38'(n_qy));
    end

    always_ff @(posedge i_clk) begin
        if (n_en) begin
            if (!r_attr_en) begin
                r4_vx <= n_sd.vx;
                r4_vy <= n_sd.vy;
            end else if (n_sd.near) begin
                r4_vx <= n_sd.vxd;
                r4_vy <= n_sd.vyd;
            end else begin
                r4_vx <= sat32(n_sumx);
                r4_vy <= sat32(n_sumy);
            end
            r4_px <= n_sd.px;
            r4_py <= n_sd.py;
        end
    end

    // S5: gravity
    logic signed [VEL_W-1:0] r5_vx, r5_vy;
    logic        [POS_W-1:0] r5_px, r5_py;
    logic        [24:0]      n_grav;

    assign n_grav = 25'(GRAV_RATE) * 25'(r_dt);

    always_ff @(posedge i_clk) begin
        if (n_en) begin
            r5_vx <= r4_vx;
            r5_vy <= r_grav_en ? sat32(38'(r4_vy) + $signed({13'b0, n_grav})) : r4_vy;
            r5_px <= r4_px;
            r5_py <= r4_py;
        end
    end

    // S6: step and bounce products
    logic signed [48:0]      r6_stx, r6_sty;
    logic signed [45:0]      r6_bx, r6_by;
    logic signed [VEL_W-1:0] r6_vx, r6_vy;
    logic        [POS_W-1:0] r6_px, r6_py;

    always_ff @(posedge i_clk) begin
        if (n_en) begin
            r6_stx <= 49'(r5_vx) * $signed({33'b0, r_dt});
            r6_sty <= 49'(r5_vy) * $signed({33'b0, r_dt});
            r6_bx  <= 46'(r5_vx) * 46'sd6554;
            r6_by  <= 46'(r5_vy) * 46'sd6554;
            r6_vx  <= r5_vx;
            r6_vy  <= r5_vy;
            r6_px  <= r5_px;
            r6_py  <= r5_py;
        end
    end

    // S7: integrate position, prepare wall bounce
    logic signed [48:0]      n_shx, n_shy;
    logic signed [45:0]      n_bsx, n_bsy;
    logic signed [33:0]      r7_px, r7_py;
    logic signed [VEL_W-1:0] r7_vx, r7_vy, r7_bx, r7_by;

    always_comb begin
        n_shx = (r6_stx + (r6_stx[48] ? 49'sd65535 : 49'sd0)) >>> 16;
        n_shy = (r6_sty + (r6_sty[48] ? 49'sd65535 : 49'sd0)) >>> 16;
        n_bsx = (r6_bx + (r6_bx[45] ? 46'sd65535 : 46'sd0)) >>> 16;
        n_bsy = (r6_by + (r6_by[45] ? 46'sd65535 : 46'sd0)) >>> 16;
    end

    always_ff @(posedge i_clk) begin
        if (n_en) begin
            r7_px <= $signed({7'b0, r6_px}) + n_shx[33:0];
            r7_py <= $signed({7'b0, r6_py}) + n_shy[33:0];
            r7_vx <= r6_vx;
            r7_vy <= r6_vy;
            r7_bx <= -n_bsx[VEL_W-1:0];
            r7_by <= -n_bsy[VEL_W-1:0];
        end
    end

    // S8: clamp to the field, output register
    logic signed [33:0]      n_cpx, n_cpy;
    logic signed [VEL_W-1:0] n_cvx, n_cvy;
    t_out_item               r_out;

    always_comb begin
        n_cpx = r7_px;
        n_cvx = r7_vx;
        if (r7_px < 34'sd0) begin
            n_cpx = '0;
            n_cvx = r7_bx;
        end else if (r7_px > X_MAX) begin
            n_cpx = X_MAX;
            n_cvx = r7_bx;
        end
        n_cpy = r7_py;
        n_cvy = r7_vy;
        if (r7_py < 34'sd0) begin
            n_cpy = '0;
            n_cvy = r7_by;
        end else if (r7_py > Y_MAX) begin
            n_cpy = Y_MAX;
            n_cvy = r7_by;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_en) begin
            r_out.new_pos_x <= n_cpx[POS_W-1:0];
            r_out.new_pos_y <= n_cpy[POS_W-1:0];
            r_out.new_vel_x <= n_cvx;
            r_out.new_vel_y <= n_cvy;
            r_out.pixel_x   <= n_cpx[16+PIX_W-1:16];
            r_out.pixel_y   <= n_cpy[16+PIX_W-1:16];
        end
    end

    assign o_data = r_out;

endmodule

// ----- rtl/pau_checker.sv -----
// Port-level checker for the particle attractor update unit, with its bind.
`timescale 1ns / 1ps
module pau_checker #(
    parameter int FIELD_WIDTH  = pau_pkg::FIELD_WIDTH_DEF,
    parameter int FIELD_HEIGHT = pau_pkg::FIELD_HEIGHT_DEF
) (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_valid,
    input logic                        o_stall,
    input pau_pkg::t_in_item           i_data,
    input logic                        o_valid,
    input logic                        i_stall,
    input pau_pkg::t_out_item          o_data,
    input logic                        i_cfg_we,
    input logic [pau_pkg::IDX_W-1:0]   i_cfg_idx,
    input logic [pau_pkg::CFG_W-1:0]   i_cfg_data
);
    import pau_pkg::*;

    localparam logic [POS_W:0] X_LIM = (POS_W+1)'(FIELD_WIDTH * 65536);
    localparam logic [POS_W:0] Y_LIM = (POS_W+1)'(FIELD_HEIGHT * 65536);

    a_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data))
        else $error("held result transaction changed");

    a_stall_only_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall == (o_valid && i_stall))
        else $error("input stalled while output free");

    a_pixel_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_data.pixel_x == o_data.new_pos_x[26:16] &&
                    o_data.pixel_y == o_data.new_pos_y[26:16])
        else $error("pixel coordinate mismatch");

    a_in_field: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && FIELD_WIDTH < 2048 && FIELD_HEIGHT < 2048 |->
            {1'b0, o_data.new_pos_x} <= X_LIM && {1'b0, o_data.new_pos_y} <= Y_LIM)
        else $error("position beyond the field");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

bind particle_attractor_update_unit pau_checker #(
    .FIELD_WIDTH  (FIELD_WIDTH),
    .FIELD_HEIGHT (FIELD_HEIGHT)
) u_pau_checker (.*);

// ----- sim/testbench.sv -----
// Testbench for the particle attractor update unit: self-checking streaming test.
`timescale 1ns / 1ps
module testbench;
    import pau_pkg::*;

    localparam longint XMAX = longint'(FIELD_WIDTH_DEF) <<< 16;
    localparam longint YMAX = longint'(FIELD_HEIGHT_DEF) <<< 16;
    localparam int SETTLE = 50;

    logic      i_clk      = 1'b0;
    logic      i_rst_n    = 1'b0;
    logic      i_valid    = 1'b0;
    logic      o_stall;
    t_in_item  i_data     = '0;
    logic      o_valid;
    logic      i_stall    = 1'b0;
    t_out_item o_data;
    logic      i_cfg_we   = 1'b0;
    logic [IDX_W-1:0] i_cfg_idx  = '0;
    logic [CFG_W-1:0] i_cfg_data = '0;

    particle_attractor_update_unit dut (.*);

    // shadow of the configuration registers
    longint unsigned att_x = 0, att_y = 0, step = 1092, strength = 421150;
    bit attr_on = 0, grav_on = 0;

    t_in_item  particles_q[$];
    t_out_item updates_q[$];
    int send_idle = 0, recv_idle = 0;
    bit failed = 0;

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    function automatic longint shr0(longint v, int s);
        if (v < 0) return -((-v) >>> s);
        return v >>> s;
    endfunction

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint pull(longint diff, logic [63:0] d2);
        logic [127:0] num;
        longint q;
        num = (128'(diff < 0 ? -diff : diff) * 128'(strength) * 128'(step)) << 16;
        q = longint'(num / {64'd0, d2});
        return diff < 0 ? -q : q;
    endfunction

    function automatic t_out_item predict_update(t_in_item it);
        longint px, py, vx, vy, dx, dy;
        logic [63:0] d2;
        t_out_item r;
        px = longint'({37'd0, it.pos_x});
        py = longint'({37'd0, it.pos_y});
        vx = longint'(it.vel_x);
        vy = longint'(it.vel_y);
        dx = longint'(att_x << 16) - px;
        dy = longint'(att_y << 16) - py;
        if (attr_on) begin
            d2 = dx * dx + dy * dy;
            if (d2 > (64'd22500 << 32)) begin
                vx = clamp32(vx + pull(dx, d2));
                vy = clamp32(vy + pull(dy, d2));
            end else begin
                vx = clamp32(vx - shr0(vx * longint'(step), 17));
                vy = clamp32(vy - shr0(vy * longint'(step), 17));
            end
        end
        if (grav_on) vy = clamp32(vy + GRAV_RATE * longint'(step));
        px += shr0(vx * longint'(step), 16);
        py += shr0(vy * longint'(step), 16);
        if (px < 0 || px > XMAX) begin
            px = px < 0 ? 0 : XMAX;
            vx = -shr0(vx * TENTH_Q16, 16);
        end
        if (py < 0 || py > YMAX) begin
            py = py < 0 ? 0 : YMAX;
            vy = -shr0(vy * TENTH_Q16, 16);
        end
        r.new_pos_x = px[POS_W-1:0];
        r.new_pos_y = py[POS_W-1:0];
        r.new_vel_x = vx[VEL_W-1:0];
        r.new_vel_y = vy[VEL_W-1:0];
        r.pixel_x   = px[16 +: PIX_W];
        r.pixel_y   = py[16 +: PIX_W];
        return r;
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) updates_q.push_back(predict_update(i_data));
            if (!i_valid || !o_stall) begin
                if (particles_q.size() > 0 && $urandom_range(99) >= send_idle) begin
                    i_data  <= particles_q.pop_front();
                    i_valid <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(string name, longint e, longint a);
        if (e != a) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $realtime, name, e, a);
            failed = 1;
        end
    endtask

    // monitor
    always @(posedge i_clk) begin
        t_out_item e;
        i_stall <= ($urandom_range(99) < recv_idle);
        if (i_rst_n && o_valid && !i_stall) begin
            if (updates_q.size() == 0) begin
                $display("%0t: unexpected transaction, actual %h", $realtime, o_data);
                failed = 1;
            end else begin
                e = updates_q.pop_front();
                check_field("new_pos_x", e.new_pos_x, o_data.new_pos_x);
                check_field("new_pos_y", e.new_pos_y, o_data.new_pos_y);
                check_field("new_vel_x", e.new_vel_x, o_data.new_vel_x);
                check_field("new_vel_y", e.new_vel_y, o_data.new_vel_y);
                check_field("pixel_x", e.pixel_x, o_data.pixel_x);
                check_field("pixel_y", e.pixel_y, o_data.pixel_y);
            end
        end
    end

    task automatic write_reg(t_cfg_idx idx, longint unsigned v);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= v[CFG_W-1:0];
    endtask

    task automatic configure(longint unsigned ax, ay, dt, str, bit aen, bit gen);
        write_reg(CFG_ATTR_X, ax);
        write_reg(CFG_ATTR_Y, ay);
        write_reg(CFG_TIME_STEP, dt);
        write_reg(CFG_STRENGTH, str);
        write_reg(CFG_ATTR_EN, aen);
        write_reg(CFG_GRAV_EN, gen);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        att_x = ax; att_y = ay; step = dt; strength = str;
        attr_on = aen; grav_on = gen;
    endtask

    task automatic drain();
        do @(posedge i_clk);
        while (particles_q.size() > 0 || i_valid || updates_q.size() > 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic add(longint unsigned px, py, longint vx, vy);
        t_in_item it;
        it.pos_x = px[POS_W-1:0];
        it.pos_y = py[POS_W-1:0];
        it.vel_x = vx[VEL_W-1:0];
        it.vel_y = vy[VEL_W-1:0];
        particles_q.push_back(it);
    endtask

    function automatic longint unsigned rand_pos(longint unsigned centre, longint unsigned lim);
        int sel;
        longint c;
        sel = $urandom_range(99);
        if (sel < 10) return {$urandom} & 32'h7FF_FFFF;
        if (sel < 20) return $urandom_range(1) ? $urandom_range(200000) :
                             (lim << 16) - $urandom_range(200000);
        if (sel < 50) begin
            c = longint'(centre << 16) + $signed($urandom_range(19660800)) - 9830400;
            return c < 0 ? 0 : longint'(c);
        end
        return (longint'($urandom) * (lim << 16)) >> 32;
    endfunction

    function automatic longint rand_vel();
        int sel;
        sel = $urandom_range(99);
        if (sel < 40) return $signed($urandom_range(8388607)) - 4194304;
        if (sel < 80) return $signed($urandom);
        if (sel < 90) return $urandom_range(1) ? 64'sd2147483647 : -64'sd2147483648;
        return $signed($urandom_range(200)) - 100;
    endfunction

    typedef struct {
        longint unsigned ax, ay, dt, str;
        bit aen, gen;
    } t_setting;

    t_setting settings[9] = '{
        '{960, 540, 1092, 421150, 1, 1},
        '{0, 0, 65535, 64'hFFFF_FFFF, 1, 0},
        '{1920, 1080, 0, 421150, 1, 1},
        '{500, 500, 1092, 4000000, 1, 0},
        '{1920, 0, 65535, 1, 0, 1},
        '{0, 1080, 30000, 421150, 0, 0},
        '{100, 900, 1, 64'hFFFF_FFFF, 1, 1},
        '{1234, 321, 4000, 10000000, 1, 1},
        '{960, 540, 1092, 421150, 1, 0}
    };

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed
        configure(500, 500, 1092, 421150, 1, 1);
        add(0, 0, 0, 0);
        add(XMAX, YMAX, 0, 0);
        add(27'h7FF_FFFF, 27'h7FF_FFFF, 2147483647, 2147483647);
        add(0, 0, -2147483648, -2147483648);
        add(XMAX, YMAX, 2147483647, 2147483647);
        add(650 << 16, 500 << 16, 1000000, -1000000);
        add(500 << 16, 350 << 16, -3000000, 3000000);
        add(500 << 16, 500 << 16, 65536, -65536);
        add(651 << 16, 500 << 16, 0, 0);
        add(10, 10, -5000000, -5000000);
        add(XMAX - 10, YMAX - 10, 5000000, 5000000);
        add(0, YMAX, -2147483648, 2147483647);
        add(XMAX, 0, 2147483647, -2147483648);
        add(1 << 16, 1 << 16, -1, -1);
        drain();
        configure(0, 0, 65535, 64'hFFFF_FFFF, 1, 1);
        add(XMAX, YMAX, 0, 0);
        add(1, 0, 2147483647, -2147483648);
        add(0, 0, 0, 0);
        add(27'h7FF_FFFF, 0, -2147483648, 2147483647);
        drain();

        // random, several register settings
        foreach (settings[p]) begin
            send_idle = p < 3 ? 29 : p < 6 ? 67 : 0;
            recv_idle = p < 3 ? 67 : p < 6 ? 29 : 0;
            configure(settings[p].ax, settings[p].ay, settings[p].dt, settings[p].str,
                      settings[p].aen, settings[p].gen);
            repeat (115)
                add(rand_pos(settings[p].ax, FIELD_WIDTH_DEF),
                    rand_pos(settings[p].ay, FIELD_HEIGHT_DEF), rand_vel(), rand_vel());
            drain();
        end

        if (!failed && updates_q.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #400000;
        $display("Some tests failed");
        $finish;
    end

endmodule
